>>> design/owb_pkg.sv
// Shared types, codes and constants of the 1-Wire bus master.
// Depends on nothing; every other design file imports it.
package owb_pkg;

    // Field widths fixed by the item formats
    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int REG_W    = 10;
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 3;

    // Defaults handed to the top-level parameters
    localparam int TIMER_BITS_DEF  = 10;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Fixed gap after each written byte, in ticks
    localparam int GAP_TICKS = 30;

    // Command codes on the mode field
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_WR1_LOW  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WR1_REC  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WR0_LOW  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WR0_REC  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RD_LOW   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RD_DELAY = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RD_REC   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_RST_TIME = 3'd7;

    typedef logic [REG_W-1:0] cfg_word_t;

    localparam cfg_word_t REG_RESET_VALS [NUM_REGS] = '{
        10'd7, 10'd60, 10'd60, 10'd15, 10'd9, 10'd15, 10'd60, 10'd500
    };

    // Dallas CRC-8, reflected polynomial
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
        logic              line_in;
    } cmd_t;

    typedef struct packed {
        logic              line_low;
        logic              busy_res;
        logic              done_res;
        logic              read_valid;
        logic [BYTE_W-1:0] read_data;
        logic              crc_valid;
        logic              crc_ok;
        logic              rejected;
    } res_t;

    // Classified item as it travels from front end to engine
    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_RESET,
        KIND_WRITE,
        KIND_READ
    } item_kind_t;

    typedef struct packed {
        item_kind_t        kind;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
        logic              line_in;
    } item_t;

    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> design/owb_front.sv
// Input side of the 1-Wire bus master: takes items and classifies them.
// Depends on owb_pkg; feeds owb_queue.
module owb_front
    import owb_pkg::*;
(
    input  logic  cmd_valid,
    output logic  cmd_stall,
    input  cmd_t  cmd,
    input  logic  queue_full,
    output logic  push,
    output item_t push_item
);

    item_kind_t kind;

    always_comb
    begin
        unique case (cmd.mode)
            MODE_TICK:  kind = KIND_TICK;
            MODE_RESET: kind = KIND_RESET;
            MODE_WRITE: kind = KIND_WRITE;
            MODE_READ:  kind = KIND_READ;
            default:    kind = KIND_TICK;
        endcase
    end

    // Hold off the sender while the queue has no room
    assign cmd_stall = queue_full;
    assign push      = cmd_valid && !queue_full;

    always_comb
    begin
        push_item.kind      = kind;
        push_item.data_byte = cmd.data_byte;
        push_item.last_byte = cmd.last_byte;
        push_item.line_in   = cmd.line_in;
    end

endmodule

>>> design/owb_queue.sv
// Short item queue between the front end and the bus engine.
// Depends on owb_pkg for the item type.
module owb_queue
    import owb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");
`endif

endmodule

>>> design/owb_engine.sv
// Bus engine of the 1-Wire bus master: slot timing, shifting, CRC, result register.
// Depends on owb_pkg; pops items from owb_queue.
module owb_engine
    import owb_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 head_valid,
    input  item_t                head_item,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_WR_LOW,
        PH_WR_REC,
        PH_WR_GAP,
        PH_RD_LOW,
        PH_RD_DELAY,
        PH_RD_REC
    } phase_t;

    localparam int EXT_W = (TIMER_BITS > REG_W) ? TIMER_BITS : REG_W;

    cfg_word_t              cfg_reg [NUM_REGS];

    phase_t                 phase_reg, phase_next;
    logic [TIMER_BITS-1:0]  tick_reg, tick_next;
    logic [2:0]             bit_reg, bit_next;
    logic [BYTE_W-1:0]      shift_reg, shift_next;
    logic [BYTE_W-1:0]      crc_reg, crc_next;
    logic                   last_reg, last_next;
    logic                   res_valid_reg, res_valid_next;
    res_t                   res_reg, res_next;

    logic                   cur_bit;
    logic [TIMER_BITS-1:0]  dur;
    logic                   over;

    function automatic logic [TIMER_BITS-1:0] to_timer(input cfg_word_t v);
        logic [EXT_W-1:0] wide;
        wide = EXT_W'(v);
        return wide[TIMER_BITS-1:0];
    endfunction

    // Take a new item whenever the result register is free or being emptied
    assign pop = head_valid && (!res_valid_reg || !res_stall);

    assign cur_bit = shift_reg[bit_reg];

    always_comb
    begin
        case (phase_reg) inside
            PH_RST_LOW, PH_RST_WAIT: dur = to_timer(cfg_reg[REG_RST_TIME]);
            PH_WR_LOW:   dur = cur_bit ? to_timer(cfg_reg[REG_WR1_LOW])
                                       : to_timer(cfg_reg[REG_WR0_LOW]);
            PH_WR_REC:   dur = cur_bit ? to_timer(cfg_reg[REG_WR1_REC])
                                       : to_timer(cfg_reg[REG_WR0_REC]);
            PH_WR_GAP:   dur = TIMER_BITS'(GAP_TICKS);
            PH_RD_LOW:   dur = to_timer(cfg_reg[REG_RD_LOW]);
            PH_RD_DELAY: dur = to_timer(cfg_reg[REG_RD_DELAY]);
            PH_RD_REC:   dur = to_timer(cfg_reg[REG_RD_REC]);
            default:     dur = '0;
        endcase
    end

    assign over = ({1'b0, tick_reg} + 1'b1) >= {1'b0, dur};

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        crc_next   = crc_reg;
        last_next  = last_reg;
        res_next   = '0;

        if (head_item.kind != KIND_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                res_next.rejected = 1'b1;
            end
            else
            begin
                bit_next  = '0;
                tick_next = '0;
                unique case (head_item.kind)
                    KIND_RESET:
                    begin
                        crc_next   = '0;
                        phase_next = PH_RST_LOW;
                    end
                    KIND_WRITE:
                    begin
                        shift_next = head_item.data_byte;
                        phase_next = PH_WR_LOW;
                    end
                    KIND_READ:
                    begin
                        shift_next = '0;
                        last_next  = head_item.last_byte;
                        phase_next = PH_RD_LOW;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
        else
        begin
            // Advance the phase timer; a finished phase restarts it at zero
            tick_next = over ? '0 : tick_reg + 1'b1;
            unique case (phase_reg)
                PH_RST_LOW:
                begin
                    if (over) phase_next = PH_RST_WAIT;
                end
                PH_RST_WAIT:
                begin
                    if (over)
                    begin
                        phase_next        = PH_IDLE;
                        res_next.done_res = 1'b1;
                    end
                end
                PH_WR_LOW:
                begin
                    if (over) phase_next = PH_WR_REC;
                end
                PH_WR_REC:
                begin
                    if (over)
                    begin
                        if (bit_reg == 3'd7)
                        begin
                            phase_next = PH_WR_GAP;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 1'b1;
                            phase_next = PH_WR_LOW;
                        end
                    end
                end
                PH_WR_GAP:
                begin
                    if (over)
                    begin
                        phase_next        = PH_IDLE;
                        res_next.done_res = 1'b1;
                    end
                end
                PH_RD_LOW:
                begin
                    if (over) phase_next = PH_RD_DELAY;
                end
                PH_RD_DELAY:
                begin
                    if (over)
                    begin
                        shift_next = {head_item.line_in, shift_reg[BYTE_W-1:1]};
                        phase_next = PH_RD_REC;
                    end
                end
                PH_RD_REC:
                begin
                    if (over)
                    begin
                        if (bit_reg == 3'd7)
                        begin
                            phase_next          = PH_IDLE;
                            res_next.done_res   = 1'b1;
                            res_next.read_valid = 1'b1;
                            res_next.read_data  = shift_reg;
                            if (last_reg)
                            begin
                                res_next.crc_valid = 1'b1;
                                res_next.crc_ok    = (crc_reg == shift_reg);
                                crc_next           = '0;
                            end
                            else
                            begin
                                crc_next = crc8_update(crc_reg, shift_reg);
                            end
                        end
                        else
                        begin
                            bit_next   = bit_reg + 1'b1;
                            phase_next = PH_RD_LOW;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            endcase
        end

        res_next.line_low = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW) ||
                            (phase_next == PH_RD_LOW);
        res_next.busy_res = (phase_next != PH_IDLE);
    end

    assign res_valid_next = pop || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= REG_RESET_VALS[i];
            end
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            crc_reg       <= '0;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
            if (pop)
            begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                crc_reg   <= crc_next;
                last_reg  <= last_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (tick_reg == '0))
        else $error("timer running while idle");
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.done_res) |-> !res_reg.busy_res)
        else $error("done reported while still busy");
    a_crc_with_read: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.crc_valid) |-> (res_reg.read_valid && res_reg.done_res))
        else $error("crc result without a finished read");
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.rejected) |-> res_reg.busy_res)
        else $error("command rejected while idle");
`endif

endmodule

>>> design/onewire_bus_master_core.sv
// Top level of the 1-Wire bus master: front end, item queue and bus engine.
// Depends on owb_pkg, owb_front, owb_queue and owb_engine.
//
// Usage:
//   The cmd channel carries one item per handshake: a tick (mode 0) with the
//   sampled bus level in line_in, or a command (bus reset, write byte, read
//   byte). Only ticks move bus time forward. An item is taken at a rising
//   edge with cmd_valid high and cmd_stall low.
//   The res channel returns exactly one result item per input item, in order:
//   the bus drive level and busy flag after the item, plus done, read byte,
//   CRC check and reject flags. A result is taken when res_valid is high and
//   res_stall is low.
//   Throughput: one item per cycle, sustained, while res_stall stays low.
//   Path: an item taken into a queue slot is popped into the engine's result
//   register when that register is free or being emptied, and shows on res.
//   Stalls: when res_stall holds the result register, the engine stops
//   popping; the queue fills and cmd_stall rises once its entries are used.
//   Reset: rst_n clears the queue, the engine returns to idle with the CRC
//   cleared, and the timing registers take their default values at once.
//   Configuration: cfg_write with cfg_index/cfg_data writes one timing
//   register; write only while no item is in flight.
module onewire_bus_master_core
    import owb_pkg::*;
#(
    parameter int TIMER_BITS  = TIMER_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  cmd_t                 cmd,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res
);

    // Front end to queue
    logic  push;
    item_t push_item;
    logic  queue_full;

    // Queue to engine
    logic  pop;
    logic  head_valid;
    item_t head_item;

    // Classify incoming items; stall the sender when the queue is full
    owb_front u_front (
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Decouple acceptance from execution so each side can stall on its own
    owb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Run bus timing one item per cycle unless a held result stalls it, and hold each result until taken
    owb_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for onewire_bus_master_core: a scoreboard class predicts each
// result item from the accepted input items; plain tasks drive commands, ticks and timings.
// Depends on owb_pkg and the design files of the bus master.
module tb;
    import owb_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int ITEM_GOAL     = 1350;
    localparam int SETTLE_CYCLES = 6;
    localparam int LAST_BIT      = 7;
    localparam int CMD_W         = $bits(cmd_t);

    // Bus phases of the predicted master
    typedef enum logic [3:0] {
        BUS_IDLE,
        BUS_RST_LOW,
        BUS_RST_WAIT,
        BUS_WR_LOW,
        BUS_WR_REC,
        BUS_WR_GAP,
        BUS_RD_LOW,
        BUS_RD_SAMPLE,
        BUS_RD_REC
    } bus_phase_t;

    // Tracks the expected bus behavior and checks result items in order
    class bus_scoreboard;
        cfg_word_t         timing [NUM_REGS];
        bus_phase_t        phase;
        logic [REG_W-1:0]  tick_count;
        logic [2:0]        bit_idx;
        logic [BYTE_W-1:0] shift_byte;
        logic [BYTE_W-1:0] crc;
        logic              reading_last;
        res_t              pending [$];
        int errors;
        int items_seen;
        int live_items;
        int done_count;
        int read_count;
        int crc_checks;
        int crc_good;
        int reject_count;

        function new();
            foreach (timing[i])
            begin
                timing[i] = REG_RESET_VALS[i];
            end
            phase        = BUS_IDLE;
            tick_count   = '0;
            bit_idx      = '0;
            shift_byte   = '0;
            crc          = '0;
            reading_last = 1'b0;
        endfunction

        function void set_timing(logic [REG_IDX_W-1:0] idx, cfg_word_t value);
            timing[idx] = value;
        endfunction

        function bit slot_over(int duration);
            return int'(tick_count) + 1 >= duration;
        endfunction

        function void advance(bus_phase_t next);
            phase      = next;
            tick_count = '0;
        endfunction

        // Dallas CRC-8, fed one data bit at a time, LSB first
        function logic [BYTE_W-1:0] crc_step(logic [BYTE_W-1:0] c, logic [BYTE_W-1:0] b);
            logic fb;
            for (int i = 0; i < BYTE_W; i++)
            begin
                fb = c[0] ^ b[i];
                c  = c >> 1;
                if (fb)
                    c = c ^ 8'h8C;
            end
            return c;
        endfunction

        // Predict the result of one accepted input item
        function void note_item(cmd_t c);
            res_t r;
            logic bit_now;
            bit   ignored;
            r       = '0;
            ignored = 1'b0;
            items_seen++;
            if (c.mode != MODE_TICK)
            begin
                if (phase != BUS_IDLE)
                begin
                    r.rejected = 1'b1;
                    ignored    = 1'b1;
                    reject_count++;
                end
                else
                begin
                    bit_idx = '0;
                    case (c.mode)
                        MODE_RESET:
                        begin
                            crc = '0;
                            advance(BUS_RST_LOW);
                        end
                        MODE_WRITE:
                        begin
                            shift_byte = c.data_byte;
                            advance(BUS_WR_LOW);
                        end
                        default:
                        begin
                            shift_byte   = '0;
                            reading_last = c.last_byte;
                            advance(BUS_RD_LOW);
                        end
                    endcase
                end
            end
            else
            begin
                bit_now = shift_byte[bit_idx];
                case (phase)
                    BUS_IDLE:
                        ignored = 1'b1;
                    BUS_RST_LOW:
                        if (slot_over(int'(timing[REG_RST_TIME]))) advance(BUS_RST_WAIT);
                        else tick_count++;
                    BUS_RST_WAIT:
                        if (slot_over(int'(timing[REG_RST_TIME])))
                        begin
                            advance(BUS_IDLE);
                            r.done_res = 1'b1;
                        end
                        else tick_count++;
                    BUS_WR_LOW:
                        if (slot_over(bit_now ? int'(timing[REG_WR1_LOW])
                                              : int'(timing[REG_WR0_LOW])))
                            advance(BUS_WR_REC);
                        else tick_count++;
                    BUS_WR_REC:
                        if (slot_over(bit_now ? int'(timing[REG_WR1_REC])
                                              : int'(timing[REG_WR0_REC])))
                        begin
                            if (bit_idx == LAST_BIT)
                                advance(BUS_WR_GAP);
                            else
                            begin
                                bit_idx++;
                                advance(BUS_WR_LOW);
                            end
                        end
                        else tick_count++;
                    BUS_WR_GAP:
                        if (slot_over(GAP_TICKS))
                        begin
                            advance(BUS_IDLE);
                            r.done_res = 1'b1;
                        end
                        else tick_count++;
                    BUS_RD_LOW:
                        if (slot_over(int'(timing[REG_RD_LOW]))) advance(BUS_RD_SAMPLE);
                        else tick_count++;
                    BUS_RD_SAMPLE:
                        if (slot_over(int'(timing[REG_RD_DELAY])))
                        begin
                            shift_byte = {c.line_in, shift_byte[BYTE_W-1:1]};
                            advance(BUS_RD_REC);
                        end
                        else tick_count++;
                    BUS_RD_REC:
                        if (slot_over(int'(timing[REG_RD_REC])))
                        begin
                            if (bit_idx == LAST_BIT)
                            begin
                                advance(BUS_IDLE);
                                r.done_res   = 1'b1;
                                r.read_valid = 1'b1;
                                r.read_data  = shift_byte;
                                read_count++;
                                if (reading_last)
                                begin
                                    r.crc_valid = 1'b1;
                                    r.crc_ok    = (crc == shift_byte);
                                    crc         = '0;
                                    crc_checks++;
                                    if (r.crc_ok)
                                        crc_good++;
                                end
                                else
                                    crc = crc_step(crc, shift_byte);
                            end
                            else
                            begin
                                bit_idx++;
                                advance(BUS_RD_LOW);
                            end
                        end
                        else tick_count++;
                    default:
                        advance(BUS_IDLE);
                endcase
            end
            r.line_low = (phase == BUS_RST_LOW) || (phase == BUS_WR_LOW) || (phase == BUS_RD_LOW);
            r.busy_res = (phase != BUS_IDLE);
            if (r.done_res)
                done_count++;
            if (!ignored)
                live_items++;
            pending.push_back(r);
        endfunction

        function void match_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        // Compare one accepted result item with the oldest prediction
        function void check_result(res_t got);
            res_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result item with nothing expected, actual %0h", $time, got);
                return;
            end
            want = pending.pop_front();
            match_field("line_low", BYTE_W'(want.line_low), BYTE_W'(got.line_low));
            match_field("busy_res", BYTE_W'(want.busy_res), BYTE_W'(got.busy_res));
            match_field("done_res", BYTE_W'(want.done_res), BYTE_W'(got.done_res));
            match_field("read_valid", BYTE_W'(want.read_valid), BYTE_W'(got.read_valid));
            match_field("read_data", want.read_data, got.read_data);
            match_field("crc_valid", BYTE_W'(want.crc_valid), BYTE_W'(got.crc_valid));
            match_field("crc_ok", BYTE_W'(want.crc_ok), BYTE_W'(got.crc_ok));
            match_field("rejected", BYTE_W'(want.rejected), BYTE_W'(got.rejected));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;
    logic                 cmd_valid;
    logic                 cmd_stall;
    cmd_t                 cmd;
    logic                 res_valid;
    logic                 res_stall;
    res_t                 res;

    bus_scoreboard sb;
    int cycle_count;
    int burst_left;
    int cfg_setups;

    onewire_bus_master_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: end the run if the cycle budget runs out
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("onewire_bus_master_core verification failed");
        $finish;
    end

    // Receiver: drive res_stall from randomly picked patterns: none, random, periodic or alternating runs
    initial
    begin
        int  pattern;
        int  pattern_left;
        int  run_left;
        int  beat;
        logic holding;
        res_stall    = 1'b0;
        pattern      = 0;
        pattern_left = 0;
        run_left     = 0;
        beat         = 0;
        holding      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pattern_left == 0)
            begin
                pattern      = $urandom_range(0, 3);
                pattern_left = $urandom_range(64, 256);
            end
            pattern_left--;
            beat++;
            case (pattern)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 3) == 0);
                2: res_stall <= (beat % 3 == 0);
                default:
                begin
                    // alternate runs of stalling and flowing
                    if (run_left == 0)
                    begin
                        holding  = ~holding;
                        run_left = holding ? $urandom_range(1, 16) : $urandom_range(1, 24);
                    end
                    run_left--;
                    res_stall <= holding;
                end
            endcase
        end
    end

    // Check every result item the receiver takes
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res);
    end

    function automatic logic rand_bit();
        return 1'($urandom);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom);
    endfunction

    function automatic cmd_t tick_item(logic line);
        cmd_t c;
        c           = '0;
        c.mode      = MODE_TICK;
        c.data_byte = rand_byte();
        c.last_byte = rand_bit();
        c.line_in   = line;
        return c;
    endfunction

    function automatic cmd_t make_cmd(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] data,
                                      logic last);
        cmd_t c;
        c.mode      = mode;
        c.data_byte = data;
        c.last_byte = last;
        c.line_in   = rand_bit();
        return c;
    endfunction

    // Offer one item, hold it until taken, then hand it to the scoreboard.
    // Call right after a rising edge; returns at the edge that took the item.
    task automatic send_item(input cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                // long stretch with no idling at all
                gap        = 0;
                burst_left = $urandom_range(100, 300);
            end
            else
            begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
            end
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        sb.note_item(c);
    endtask

    // Tick until the master goes idle. Present the bits of target on the sample ticks of
    // a read and random levels elsewhere; now and then throw in a command that must bounce.
    task automatic drive_to_idle(input logic [BYTE_W-1:0] target);
        cmd_t c;
        logic line;
        while (sb.phase != BUS_IDLE)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: c = make_cmd(MODE_RESET, rand_byte(), rand_bit());
                    1: c = make_cmd(MODE_WRITE, rand_byte(), rand_bit());
                    default: c = make_cmd(MODE_READ, rand_byte(), rand_bit());
                endcase
            end
            else
            begin
                line = (sb.phase == BUS_RD_SAMPLE) ? target[sb.bit_idx] : rand_bit();
                c    = tick_item(line);
            end
            send_item(c);
        end
    endtask

    task automatic run_command(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
                               input logic last, input logic [BYTE_W-1:0] target);
        send_item(make_cmd(mode, data, last));
        drive_to_idle(target);
    endtask

    // Drop valid and wait until every predicted result item has come back
    task automatic settle();
        cmd_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timing(input logic [REG_IDX_W-1:0] idx, input cfg_word_t value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_timing(idx, value);
        @(posedge clk);
    endtask

    task automatic apply_timings(input cfg_word_t vals [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++)
            write_timing(REG_IDX_W'(i), vals[i]);
        cfg_setups++;
    endtask

    // One well-formed command sequence with random content, or a burst of noise
    task automatic random_sequence();
        int pick;
        int reads;
        logic [BYTE_W-1:0] b;
        logic [CMD_W-1:0] raw;
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) send_item(tick_item(rand_bit()));
        pick = $urandom_range(0, 99);
        if (pick < 15)
            run_command(MODE_RESET, rand_byte(), rand_bit(), rand_byte());
        else if (pick < 40)
        begin
            b = rand_byte();
            case ($urandom_range(0, 9))
                0: b = 8'h00;
                1: b = 8'hFF;
                default: ;
            endcase
            run_command(MODE_WRITE, b, rand_bit(), rand_byte());
        end
        else if (pick < 58)
            run_command(MODE_READ, rand_byte(), rand_bit(), rand_byte());
        else if (pick < 88)
        begin
            // a block of reads closed by a CRC byte, mostly a matching one
            if ($urandom_range(0, 1) == 0)
                run_command(MODE_RESET, rand_byte(), rand_bit(), rand_byte());
            reads = $urandom_range(1, 3);
            repeat (reads) run_command(MODE_READ, rand_byte(), 1'b0, rand_byte());
            b = ($urandom_range(0, 3) != 0) ? sb.crc : rand_byte();
            run_command(MODE_READ, rand_byte(), 1'b1, b);
        end
        else
        begin
            repeat ($urandom_range(3, 20))
            begin
                raw = CMD_W'($urandom);
                send_item(raw);
            end
            drive_to_idle(rand_byte());
        end
    endtask

    initial
    begin
        cfg_word_t setup [NUM_REGS];
        sb         = new();
        burst_left = 0;
        cfg_setups = 1;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        cmd_valid  = 1'b0;
        cmd        = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Default timings: idle ticks, then a byte write with every command bounced while busy
        send_item(tick_item(1'b0));
        send_item(tick_item(1'b1));
        send_item(make_cmd(MODE_WRITE, 8'hFF, 1'b0));
        send_item(make_cmd(MODE_RESET, 8'h00, 1'b1));
        send_item(make_cmd(MODE_READ, 8'h00, 1'b1));
        send_item(make_cmd(MODE_WRITE, 8'h00, 1'b0));
        drive_to_idle(8'h00);
        settle();

        // Zero durations behave as one tick; extreme bytes and both CRC outcomes
        foreach (setup[i]) setup[i] = '0;
        apply_timings(setup);
        run_command(MODE_RESET, 8'h00, 1'b0, 8'h00);
        run_command(MODE_WRITE, 8'h00, 1'b0, 8'h00);
        run_command(MODE_WRITE, 8'hFF, 1'b1, 8'hFF);
        run_command(MODE_READ, 8'h00, 1'b0, 8'hFF);
        run_command(MODE_READ, 8'hFF, 1'b1, sb.crc);
        run_command(MODE_READ, 8'h00, 1'b1, 8'h80);
        settle();

        // Random part: short timings, reprogrammed between groups, until the item budget is used
        while (sb.items_seen < ITEM_GOAL)
        begin
            case ($urandom_range(0, 9))
                0: foreach (setup[i]) setup[i] = 10'd1;
                1: foreach (setup[i]) setup[i] = '0;
                default:
                    foreach (setup[i])
                        setup[i] = ($urandom_range(0, 7) == 0) ? REG_W'($urandom_range(0, 10))
                                                                : REG_W'($urandom_range(1, 4));
            endcase
            apply_timings(setup);
            repeat ($urandom_range(1, 3)) random_sequence();
            settle();
        end

        settle();
        $display("Checked %0d result items (%0d bus-active): %0d commands done, %0d bytes read,",
                 sb.items_seen, sb.live_items, sb.done_count, sb.read_count);
        $display("%0d CRC checks (%0d matched), %0d busy rejects, %0d timing setups.",
                 sb.crc_checks, sb.crc_good, sb.reject_count, cfg_setups);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("onewire_bus_master_core verification clean");
        else
            $display("onewire_bus_master_core verification failed");
        $finish;
    end

endmodule

>>> filelist.f
design/owb_pkg.sv
design/owb_front.sv
design/owb_queue.sv
design/owb_engine.sv
design/onewire_bus_master_core.sv
sim/tb.sv
